// File: rtl/hhbt_pkg.sv
// ----------------------------------------------------------------------------
// hhbt_pkg
// Shared types and constants for the HTTP header block tokenizer.
// ----------------------------------------------------------------------------
package hhbt_pkg;

    // Result kinds
    localparam logic [2:0] K_START_BYTE = 3'd0;
    localparam logic [2:0] K_START_END  = 3'd1;
    localparam logic [2:0] K_NAME_BYTE  = 3'd2;
    localparam logic [2:0] K_VALUE_BYTE = 3'd3;
    localparam logic [2:0] K_FIELD_END  = 3'd4;
    localparam logic [2:0] K_BLOCK_END  = 3'd5;
    localparam logic [2:0] K_ERROR      = 3'd6;

    // Error codes
    localparam logic [2:0] E_NONE        = 3'd0;
    localparam logic [2:0] E_INCOMPLETE  = 3'd1;
    localparam logic [2:0] E_NO_START    = 3'd2;
    localparam logic [2:0] E_NO_COLON    = 3'd3;
    localparam logic [2:0] E_WS_OVERFLOW = 3'd4;

    // Characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [15:0] HDR_LEN_MAX = 16'hFFFF;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_DISPATCH   = 4'd1,
        OP_PLAIN      = 4'd2,
        OP_CONTENT    = 4'd3,
        OP_DRAIN_RD   = 4'd4,
        OP_DRAIN_EMIT = 4'd5,
        OP_LINE_END   = 4'd6,
        OP_FINISH     = 4'd7
    } op_t;

    typedef struct packed {
        logic ready;    // take a request this cycle
        op_t  op;
        logic use_cr;   // content step works on a held-back CR
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic done;       // block ended or failed
        logic eod;
        logic prev_cr;
        logic byte_is_cr;
        logic byte_is_lf;
        logic need_drain;
        logic drain_last;
        logic can_emit;
        logic out_free;
        logic hold_valid;
    } status_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  kind;
        logic [2:0]  error_code;
        logic [15:0] header_length;
    } res_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

// File: rtl/hhbt_ctrl.sv
// ----------------------------------------------------------------------------
// hhbt_ctrl
// Sequencer for the tokenizer: steps one request through dispatch, content,
// whitespace drain, line end and result flush.
// ----------------------------------------------------------------------------
module hhbt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  hhbt_pkg::status_t status,
    output hhbt_pkg::cmd_t    cmd
);
    import hhbt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_DISPATCH   = 8'b0000_0010,
        S_PLAIN      = 8'b0000_0100,
        S_CONTENT    = 8'b0000_1000,
        S_DRAIN_RD   = 8'b0001_0000,
        S_DRAIN_EMIT = 8'b0010_0000,
        S_LINE_END   = 8'b0100_0000,
        S_FINISH     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   cr_first_reg, cr_first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cr_first_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cr_first_reg <= cr_first_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cr_first_next = cr_first_reg;
        cmd.ready     = 1'b0;
        cmd.op        = OP_NONE;
        cmd.use_cr    = cr_first_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (status.in_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                cmd.op = OP_DISPATCH;
                if (status.done)
                    state_next = S_IDLE;
                else if (status.prev_cr && status.byte_is_lf)
                    state_next = S_LINE_END;
                else if (status.prev_cr)
                begin
                    cr_first_next = 1'b1;
                    state_next    = S_CONTENT;
                end
                else if (status.byte_is_cr)
                    state_next = S_FINISH;
                else
                    state_next = S_CONTENT;
            end
            S_PLAIN:
            begin
                cmd.op = OP_PLAIN;
                if (status.done || status.byte_is_cr)
                    state_next = S_FINISH;
                else
                    state_next = S_CONTENT;
            end
            S_CONTENT:
            begin
                if (status.can_emit)
                begin
                    if (status.need_drain)
                        state_next = S_DRAIN_RD;
                    else
                    begin
                        cmd.op        = OP_CONTENT;
                        cr_first_next = 1'b0;
                        state_next    = cr_first_reg ? S_PLAIN : S_FINISH;
                    end
                end
            end
            S_DRAIN_RD:
            begin
                cmd.op     = OP_DRAIN_RD;
                state_next = S_DRAIN_EMIT;
            end
            S_DRAIN_EMIT:
            begin
                if (status.can_emit)
                begin
                    cmd.op     = OP_DRAIN_EMIT;
                    state_next = status.drain_last ? S_CONTENT : S_DRAIN_RD;
                end
            end
            S_LINE_END:
            begin
                if (status.can_emit)
                begin
                    cmd.op     = OP_LINE_END;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.eod && !status.done)
                    cmd.op = OP_FINISH;
                else if (status.hold_valid)
                begin
                    if (status.out_free)
                    begin
                        cmd.op     = OP_FINISH;
                        state_next = S_IDLE;
                    end
                end
                else
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/hhbt_datapath.sv
// ----------------------------------------------------------------------------
// hhbt_datapath
// Parser state, whitespace buffer, result staging and output register.
// ----------------------------------------------------------------------------
module hhbt_datapath #(
    parameter int PENDING_DEPTH = 32,
    parameter int LENGTH_WIDTH  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hhbt_pkg::cmd_t    cmd,
    output hhbt_pkg::status_t status,
    input  logic              s_tvalid,
    input  logic [7:0]        s_tdata,
    input  logic [0:0]        s_tuser,
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);
    import hhbt_pkg::*;

    localparam int AW      = $clog2(PENDING_DEPTH);
    localparam int CW      = $clog2(PENDING_DEPTH + 1);
    localparam int LEN_EXT = (LENGTH_WIDTH > 16) ? LENGTH_WIDTH : 16;

    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_NAME   = 5'b00010,
        PH_VALUE  = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_FAILED = 5'b10000
    } phase_t;

    // Parser control state
    phase_t                  phase_reg, phase_next;
    logic                    prev_cr_reg, prev_cr_next;
    logic                    line_start_reg, line_start_next;
    logic                    seg_content_reg, seg_content_next;
    logic                    start_nonempty_reg, start_nonempty_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [LENGTH_WIDTH-1:0] counter_reg, counter_next;
    logic [AW-1:0]           drain_idx_reg, drain_idx_next;
    logic                    hold_valid_reg, hold_valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_last_reg, out_last_next;

    // Payload
    logic [7:0] byte_reg;
    logic       eod_reg;
    logic [7:0] rd_data_reg;
    res_t       hold_res_reg;
    res_t       out_res_reg;
    logic [7:0] pend_mem [PENDING_DEPTH];

    logic                accept;
    logic [7:0]          ch;
    logic                ch_ws;
    logic                done;
    logic [2:0]          seg_kind;
    logic                emit_req, emit_en, flush;
    res_t                new_res;
    logic                mem_we;
    logic                out_free, can_emit;
    logic [LEN_EXT-1:0]  cnt_ext;
    logic [15:0]         len_sat;

    assign accept   = s_tvalid && cmd.ready;
    assign ch       = cmd.use_cr ? CH_CR : byte_reg;
    assign ch_ws    = is_ws(ch);
    assign done     = (phase_reg == PH_DONE) || (phase_reg == PH_FAILED);
    assign seg_kind = (phase_reg == PH_NAME) ? K_NAME_BYTE : K_VALUE_BYTE;
    assign out_free = !out_valid_reg || m_tready;
    assign can_emit = !hold_valid_reg || out_free;
    assign cnt_ext  = LEN_EXT'(counter_reg);
    assign len_sat  = (cnt_ext > LEN_EXT'(HDR_LEN_MAX)) ? HDR_LEN_MAX : cnt_ext[15:0];

    // Results of a byte that ends the data are dropped unless they end the block
    assign emit_en = emit_req &&
                     (!eod_reg || (new_res.kind == K_ERROR) || (new_res.kind == K_BLOCK_END));

    assign status.in_valid   = s_tvalid;
    assign status.done       = done;
    assign status.eod        = eod_reg;
    assign status.prev_cr    = prev_cr_reg;
    assign status.byte_is_cr = (byte_reg == CH_CR);
    assign status.byte_is_lf = (byte_reg == CH_LF);
    assign status.need_drain = ((phase_reg == PH_NAME) || (phase_reg == PH_VALUE)) &&
                               !((phase_reg == PH_NAME) && (ch == CH_COLON)) &&
                               !ch_ws && (count_reg != '0);
    assign status.drain_last = ((CW'(drain_idx_reg) + CW'(1)) == count_reg);
    assign status.can_emit   = can_emit;
    assign status.out_free   = out_free;
    assign status.hold_valid = hold_valid_reg;

    always_comb
    begin
        phase_next          = phase_reg;
        prev_cr_next        = prev_cr_reg;
        line_start_next     = line_start_reg;
        seg_content_next    = seg_content_reg;
        start_nonempty_next = start_nonempty_reg;
        count_next          = count_reg;
        counter_next        = counter_reg;
        drain_idx_next      = drain_idx_reg;
        emit_req            = 1'b0;
        flush               = 1'b0;
        mem_we              = 1'b0;
        new_res             = '0;

        if (accept && s_tuser[0])
        begin
            phase_next          = PH_START;
            prev_cr_next        = 1'b0;
            line_start_next     = 1'b1;
            seg_content_next    = 1'b0;
            start_nonempty_next = 1'b0;
            count_next          = '0;
            counter_next        = '0;
        end

        unique case (cmd.op)
            OP_NONE, OP_DRAIN_RD:
            begin
            end
            OP_DISPATCH:
            begin
                if (!done)
                begin
                    if (counter_reg != '1)
                        counter_next = counter_reg + 1'b1;
                    if (prev_cr_reg)
                        prev_cr_next = 1'b0;
                    else if (byte_reg == CH_CR)
                        prev_cr_next = 1'b1;
                end
            end
            OP_PLAIN:
            begin
                if (!done && (byte_reg == CH_CR))
                    prev_cr_next = 1'b1;
            end
            OP_CONTENT:
            begin
                if (phase_reg == PH_START)
                begin
                    emit_req            = 1'b1;
                    new_res.out_byte    = ch;
                    new_res.kind        = K_START_BYTE;
                    start_nonempty_next = 1'b1;
                end
                else
                begin
                    line_start_next = 1'b0;
                    if ((phase_reg == PH_NAME) && (ch == CH_COLON))
                    begin
                        count_next       = '0;
                        seg_content_next = 1'b0;
                        phase_next       = PH_VALUE;
                    end
                    else if (ch_ws)
                    begin
                        if (seg_content_reg)
                        begin
                            if (count_reg >= CW'(PENDING_DEPTH))
                            begin
                                emit_req           = 1'b1;
                                new_res.kind       = K_ERROR;
                                new_res.error_code = E_WS_OVERFLOW;
                                phase_next         = PH_FAILED;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        emit_req         = 1'b1;
                        new_res.out_byte = ch;
                        new_res.kind     = seg_kind;
                        seg_content_next = 1'b1;
                    end
                end
            end
            OP_DRAIN_EMIT:
            begin
                emit_req         = 1'b1;
                new_res.out_byte = rd_data_reg;
                new_res.kind     = seg_kind;
                if (status.drain_last)
                begin
                    drain_idx_next = '0;
                    count_next     = '0;
                end
                else
                    drain_idx_next = drain_idx_reg + 1'b1;
            end
            OP_LINE_END:
            begin
                emit_req = 1'b1;
                if (phase_reg == PH_START)
                begin
                    if (!start_nonempty_reg)
                    begin
                        new_res.kind       = K_ERROR;
                        new_res.error_code = E_NO_START;
                        phase_next         = PH_FAILED;
                    end
                    else
                    begin
                        new_res.kind     = K_START_END;
                        phase_next       = PH_NAME;
                        line_start_next  = 1'b1;
                        seg_content_next = 1'b0;
                        count_next       = '0;
                    end
                end
                else if (phase_reg == PH_NAME)
                begin
                    if (line_start_reg)
                    begin
                        new_res.kind          = K_BLOCK_END;
                        new_res.header_length = len_sat;
                        phase_next            = PH_DONE;
                    end
                    else
                    begin
                        new_res.kind       = K_ERROR;
                        new_res.error_code = E_NO_COLON;
                        phase_next         = PH_FAILED;
                    end
                end
                else
                begin
                    new_res.kind     = K_FIELD_END;
                    phase_next       = PH_NAME;
                    line_start_next  = 1'b1;
                    seg_content_next = 1'b0;
                    count_next       = '0;
                end
            end
            OP_FINISH:
            begin
                if (eod_reg && !done)
                begin
                    emit_req           = 1'b1;
                    new_res.kind       = K_ERROR;
                    new_res.error_code = E_INCOMPLETE;
                    phase_next         = PH_FAILED;
                end
                else if (hold_valid_reg && out_free)
                    flush = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Staging: the newest result waits in hold until the next one or the flush
    // tells whether it is the last of its request.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        if (emit_en)
        begin
            hold_valid_next = 1'b1;
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_last_next  = 1'b0;
            end
            else if (m_tready)
                out_valid_next = 1'b0;
        end
        else if (flush)
        begin
            hold_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_last_next   = 1'b1;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_START;
            prev_cr_reg        <= 1'b0;
            line_start_reg     <= 1'b1;
            seg_content_reg    <= 1'b0;
            start_nonempty_reg <= 1'b0;
            count_reg          <= '0;
            counter_reg        <= '0;
            drain_idx_reg      <= '0;
            hold_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_last_reg       <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            prev_cr_reg        <= prev_cr_next;
            line_start_reg     <= line_start_next;
            seg_content_reg    <= seg_content_next;
            start_nonempty_reg <= start_nonempty_next;
            count_reg          <= count_next;
            counter_reg        <= counter_next;
            drain_idx_reg      <= drain_idx_next;
            hold_valid_reg     <= hold_valid_next;
            out_valid_reg      <= out_valid_next;
            out_last_reg       <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= s_tdata;
            eod_reg  <= s_tlast;
        end
        if (emit_en)
        begin
            hold_res_reg <= new_res;
            if (hold_valid_reg)
                out_res_reg <= hold_res_reg;
        end
        else if (flush)
            out_res_reg <= hold_res_reg;
    end

    // Trailing whitespace buffer
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pend_mem[count_reg[AW-1:0]] <= ch;
        if (cmd.op == OP_DRAIN_RD)
            rd_data_reg <= pend_mem[drain_idx_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {5'b0, out_res_reg.header_length, out_res_reg.error_code,
                       out_res_reg.out_byte};

endmodule

// File: rtl/http_header_block_tokenizer.sv
// ----------------------------------------------------------------------------
// http_header_block_tokenizer
// Ordering: a held-back CR or a whitespace release is emitted before the
//   result of the new byte; an incomplete error comes last.
// Requests: one at a time; a new request is taken only after the previous
//   one has flushed its results, and a release emits each buffered byte in turn.
// Reset: rst_n clears parser state to the start line; buffer contents undefined.
// ----------------------------------------------------------------------------
//
// Tokenizes an HTTP header block one byte per request. The start line passes
// through verbatim; each later line splits at its first colon into a name and
// a value, trimmed of leading and trailing whitespace. Trailing whitespace is
// parked in a small buffer and released only when a non-space byte follows.
// A CR is held back one byte since it may open a CRLF. The first empty line
// ends the block and reports the header length.
//
// The controller (hhbt_ctrl) walks each request through dispatch, content,
// drain and line-end steps; the datapath (hhbt_datapath) holds the parser
// state, the whitespace buffer and the result staging. The newest result is
// staged one slot behind the output register so the final result of each
// request can carry tlast.
module http_header_block_tokenizer #(
    parameter int PENDING_DEPTH = 32,   // whitespace buffer depth, 2..63
    parameter int LENGTH_WIDTH  = 16    // byte counter width, 8..32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] first_of_message
    input  logic        s_tlast,   // end_of_data
    // Result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [10:8] error_code,
                                   // [26:11] header_length, [31:27] zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // last_of_run
);
    import hhbt_pkg::*;

    cmd_t    cmd;
    status_t status;

    hhbt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    hhbt_datapath #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .LENGTH_WIDTH  (LENGTH_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Take a new request only once the previous one has flushed its results
    assign s_tready = cmd.ready;

`ifndef NO_ASSERTIONS
    // Staged result must be flushed before a new request is taken
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !status.hold_valid)
        else $error("result still staged while taking a request");

    // Errors and block end always carry the last flag of their request
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ((m_tuser == K_ERROR) || (m_tuser == K_BLOCK_END))) |-> m_tlast)
        else $error("terminating result without last flag");

    // Header length is only reported with block end
    a_len_only_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != K_BLOCK_END)) |-> (m_tdata[26:11] == 16'd0))
        else $error("header length outside block end");
`endif

endmodule
